// File: design/deq_pkg.sv
// shared codes, widths and control types of the double-ended queue
package deq_pkg;

    // fixed field widths on the stream ports
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((FUNC_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + DATA_W + OCC_W + 7) / 8) * 8;

    // default sizes
    localparam int CAPACITY_DEF      = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_BACK  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // control from the index unit to the memory and result logic
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [STATUS_W-1:0] status;
    } t_deq_ctl;

endpackage

// File: design/deq_ptr.sv
// front and back indices, element count and operation decode
module deq_ptr
    import deq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [FUNC_W-1:0] i_func,
    output t_deq_ctl          o_ctl,
    output logic [IDX_W-1:0]  o_wr_addr,
    output logic [IDX_W-1:0]  o_rd_addr,
    output logic [CNT_W-1:0]  o_count,
    output logic [CNT_W-1:0]  o_count_next
);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] front_next, front_prev, back_next, back_prev;
    logic             is_push, is_read, full, empty;

    // ring neighbors with wrap at the capacity
    assign front_next = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;
    assign front_prev = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign back_next  = (r_back == LAST_SLOT) ? '0 : r_back + 1'b1;
    assign back_prev  = (r_back == '0) ? LAST_SLOT : r_back - 1'b1;

    assign is_push = (i_func == FUNC_PUSH_BACK) || (i_func == FUNC_PUSH_FRONT);
    assign is_read = (i_func == FUNC_POP_FRONT) || (i_func == FUNC_POP_BACK)
                  || (i_func == FUNC_PEEK_FRONT) || (i_func == FUNC_PEEK_BACK);
    assign full    = (r_count == FULL_CNT);
    assign empty   = (r_count == '0);

    // operation decode and next index values
    always_comb begin
        n_front          = r_front;
        n_back           = r_back;
        n_count          = r_count;
        o_ctl            = '0;
        o_ctl.status     = ST_DONE;
        o_wr_addr        = r_back;
        o_rd_addr        = r_front;
        if (is_push && full) begin
            o_ctl.status = ST_FULL;
        end else if (is_read && empty) begin
            o_ctl.status = ST_EMPTY;
        end else begin
            unique case (i_func)
                FUNC_PUSH_BACK: begin
                    o_ctl.wr_en = 1'b1;
                    o_wr_addr   = r_back;
                    n_back      = back_next;
                    n_count     = r_count + 1'b1;
                end
                FUNC_PUSH_FRONT: begin
                    o_ctl.wr_en = 1'b1;
                    o_wr_addr   = front_prev;
                    n_front     = front_prev;
                    n_count     = r_count + 1'b1;
                end
                FUNC_POP_FRONT: begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = r_front;
                    n_front     = front_next;
                    n_count     = r_count - 1'b1;
                end
                FUNC_POP_BACK: begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = back_prev;
                    n_back      = back_prev;
                    n_count     = r_count - 1'b1;
                end
                FUNC_PEEK_FRONT: begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = r_front;
                end
                FUNC_PEEK_BACK: begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = back_prev;
                end
                default: begin
                end
            endcase
        end
    end

    // index and count registers update on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;

endmodule

// File: design/double_ended_queue_unit.sv
// Bounded double-ended queue held in a ring of CAPACITY elements in one synchronous memory.
// Each transfer on the slave stream carries one operation (push back, push front, pop front,
// pop back, peek front, peek back) and yields exactly one result on the master stream with a
// status, the element read and the element count after the operation. Pushes, rejected
// operations and unused codes go straight to the output register; pops and peeks first
// wait for the registered read of the element memory. A result waiting in the output register
// holds off the next operation until the master side takes it, which may be in the same
// cycle. The memory needs no clearing after reset, since only live entries are ever read.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // func, data_in
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata    // status, data_out, occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    logic                     r_state, n_state;
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [OCC_W-1:0]         r_occ;
    logic                     r_sel_mem;
    logic [ELEMENT_WIDTH-1:0] r_rd_data;

    logic                     fire;
    logic [FUNC_W-1:0]        func;
    logic [DATA_W-1:0]        data_in;
    logic [63:0]              wr_wide;
    logic [63:0]              rd_wide;
    logic [DATA_W-1:0]        data_out;
    t_deq_ctl                 ctl;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         count_next;

    // unpack the slave transfer
    assign func    = i_s_tdata[FUNC_W-1:0];
    assign data_in = i_s_tdata[FUNC_W +: DATA_W];
    assign wr_wide = 64'(data_in);

    // take a new operation when idle and the result slot frees up
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign fire       = i_s_tvalid && o_s_tready;

    deq_ptr #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ptr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_func       (func),
        .o_ctl        (ctl),
        .o_wr_addr    (wr_addr),
        .o_rd_addr    (rd_addr),
        .o_count      (count),
        .o_count_next (count_next)
    );

    // element memory, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fire && ctl.wr_en) begin
            mem[wr_addr] <= wr_wide[ELEMENT_WIDTH-1:0];
        end
        if (fire && ctl.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // sequencer: reads wait in S_READ for memory data
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (fire && ctl.rd_en) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_out_valid <= 1'b1;
            end else if (fire) begin
                r_out_valid <= !ctl.rd_en;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload captured at the transfer
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= ctl.status;
            r_occ     <= OCC_W'(count_next);
            r_sel_mem <= ctl.rd_en;
        end
    end

    // pack the master transfer
    assign rd_wide    = 64'(r_rd_data);
    assign data_out   = r_sel_mem ? rd_wide[DATA_W-1:0] : '0;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_occ, data_out, r_status});

`ifndef SYNTHESIS
    // a read operation always spends its next cycle waiting for memory data
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ctl.rd_en) |=> (r_state == S_READ))
        else $error("read did not enter the wait state");

    // no operation is taken while memory data is pending
    a_no_take_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_s_tready)
        else $error("operation taken during pending read");

    // a result appears right after the memory wait
    a_result_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> o_m_tvalid)
        else $error("read result not presented");

    // element count stays within the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    // memory is never written and read by the same operation
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.wr_en && ctl.rd_en))
        else $error("memory read and write together");
`endif

endmodule
